[sv/scg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scg_pkg: shared types and constants for the spherical color gradient
// Payload structs, sequencer states, CORDIC angle table.
// ----------------------------------------------------------------------------
package scg_pkg;

    localparam int MaxPointsDef = 16;
    localparam logic signed [15:0] HalfPiQ13 = 16'sd12868;
    localparam int CordicSteps = 17;
    localparam logic signed [31:0] GainInvQ30 = 32'sd652032874;

    localparam logic FuncLoad = 1'b0;
    localparam logic FuncEval = 1'b1;

    typedef struct packed {
        logic              func;
        logic [3:0]        point_index;
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic signed [15:0] point_z;
        logic [16:0]       position;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] color_x;
        logic signed [15:0] color_y;
        logic signed [15:0] color_z;
    } t_out_item;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SQ_MUL,
        S_SQRT_RHO,
        S_SQRT_RAD,
        S_ATAN_POL,
        S_ATAN_AZI,
        S_WRITE,
        S_RD_A,
        S_RD_B,
        S_LERP_MUL,
        S_LERP_ADD,
        S_SC_POL,
        S_SC_AZI,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_OUT
    } t_state;

    function automatic logic [16:0] atan_tab(input logic [4:0] i);
        logic [16:0] v;
        case (i)
            5'd0:  v = 17'd51472;
            5'd1:  v = 17'd30386;
            5'd2:  v = 17'd16055;
            5'd3:  v = 17'd8150;
            5'd4:  v = 17'd4091;
            5'd5:  v = 17'd2047;
            5'd6:  v = 17'd1024;
            5'd7:  v = 17'd512;
            5'd8:  v = 17'd256;
            5'd9:  v = 17'd128;
            5'd10: v = 17'd64;
            5'd11: v = 17'd32;
            5'd12: v = 17'd16;
            5'd13: v = 17'd8;
            5'd14: v = 17'd4;
            5'd15: v = 17'd2;
            5'd16: v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
        if (v > 48'sd32767) return 16'sd32767;
        if (v < -48'sd32768) return -16'sd32768;
        return v[15:0];
    endfunction

endpackage

[sv/scg_cordic.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scg_cordic: shared iterative CORDIC, one micro-rotation per cycle
// Vectoring mode gives atan(num/den) in Q3.13; rotation mode gives sin/cos Q.30.
// ----------------------------------------------------------------------------
module scg_cordic (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_rotate,
    input  logic signed [16:0]  i_num,
    input  logic signed [16:0]  i_den,
    input  logic signed [15:0]  i_angle,
    output logic                o_done,
    output logic signed [15:0]  o_atan,
    output logic signed [35:0]  o_sin,
    output logic signed [35:0]  o_cos
);
    import scg_pkg::*;

    // vectoring: x up to ~2^16*2^17*1.65, keep 38 bits signed
    logic signed [37:0] r_x, r_y, n_x, n_y;
    logic signed [20:0] r_z, n_z;
    logic [4:0]         r_i;
    logic               r_busy, r_rot, r_done;
    logic signed [37:0] w_xs, w_ys;
    logic signed [20:0] w_t;
    logic               w_dir;

    assign w_xs = r_x >>> r_i;
    assign w_ys = r_y >>> r_i;
    assign w_t  = {4'd0, atan_tab(r_i)};
    assign w_dir = r_rot ? (r_z >= 0) : (r_y >= 0);

    always_comb begin
        if (w_dir) begin
            n_x = r_rot ? r_x - w_ys : r_x + w_ys;
            n_y = r_rot ? r_y + w_xs : r_y - w_xs;
            n_z = r_rot ? r_z - w_t : r_z + w_t;
        end else begin
            n_x = r_rot ? r_x + w_ys : r_x - w_ys;
            n_y = r_rot ? r_y - w_xs : r_y + w_xs;
            n_z = r_rot ? r_z + w_t : r_z - w_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
            r_rot  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
                r_rot  <= i_rotate;
                if (i_rotate) begin
                    r_x <= 38'(GainInvQ30);
                    r_y <= '0;
                    r_z <= 21'(i_angle) <<< 3;
                end else begin
                    r_x <= (i_den < 0 ? 38'(-i_den) : 38'(i_den)) <<< 16;
                    r_y <= (i_den < 0 ? 38'(-i_num) : 38'(i_num)) <<< 16;
                    r_z <= '0;
                end
            end else if (r_busy) begin
                r_x <= n_x;
                r_y <= n_y;
                r_z <= n_z;
                r_i <= r_i + 5'd1;
                if (r_i == 5'(CordicSteps - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    logic signed [20:0] w_acc;
    assign w_acc  = (r_z + 21'sd4) >>> 3;
    assign o_atan = w_acc[15:0];
    assign o_sin  = r_y[35:0];
    assign o_cos  = r_x[35:0];
    assign o_done = r_done;
endmodule

[sv/spherical_color_gradient.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spherical_color_gradient: palette generator with spherical interpolation
// Control colors stored in spherical form; evaluates a gradient at t.
// ----------------------------------------------------------------------------
// One transaction at a time; the input stalls whenever the sequencer is not
// idle. A load passes a squaring state (S_SQ_MUL), two restoring square
// roots (one result bit per cycle), two CORDIC atan runs on the shared unit
// (a zero divisor skips its run) and one memory write. An evaluate takes two
// memory reads, the interpolation multiply and add, two CORDIC sin/cos runs,
// the multiplies in S_MUL1 to S_MUL3 and the output state, which hands the
// result to the output register. The shared CORDIC and the serial square
// root set the busy time. A finished evaluate waits in its output state
// while the output register still holds an unaccepted result; loads never
// wait on the output. The point store is one synchronous RAM of 48-bit
// words (radius, polar, azimuth) with a registered read. Position zero or
// above one returns point 0. Loads to slots at or beyond MAX_POINTS are
// dropped. num_points is clamped to [2, MAX_POINTS].
// ----------------------------------------------------------------------------
module spherical_color_gradient #(
    parameter int MAX_POINTS = scg_pkg::MaxPointsDef
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [4:0]           i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  scg_pkg::t_in_item    i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output scg_pkg::t_out_item   o_out_data
);
    import scg_pkg::*;

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    t_state r_state, n_state;
    logic [4:0]  r_num_points;
    t_in_item    r_item;

    // point store
    logic [47:0] r_mem [MAX_POINTS];
    logic [47:0] r_rdata;
    logic        w_mem_we, w_mem_re;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [47:0] w_wdata;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) r_mem[w_waddr] <= w_wdata;
        if (w_mem_re) r_rdata <= r_mem[w_raddr];
    end

    // square root, one result bit per cycle (restoring, 34-bit radicand)
    logic [33:0] r_rad;
    logic [33:0] r_rem;
    logic [16:0] r_root;
    logic [4:0]  r_sq_i;
    logic [33:0] r_sq_xy, r_sq_zz;
    logic [16:0] r_rho, r_radius;
    logic        r_sq_phase;
    logic [33:0] w_trial;
    logic [33:0] w_rem_sh;

    assign w_rem_sh = {r_rem[31:0], r_rad[33:32]};
    assign w_trial  = {15'd0, r_root, 2'b01};

    // CORDIC
    logic               w_c_start, w_c_rot, w_c_done;
    logic signed [16:0] w_c_num, w_c_den;
    logic signed [15:0] w_c_ang, w_c_atan;
    logic signed [35:0] w_c_sin, w_c_cos;
    logic               r_c_started;

    scg_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_c_start),
        .i_rotate(w_c_rot),
        .i_num   (w_c_num),
        .i_den   (w_c_den),
        .i_angle (w_c_ang),
        .o_done  (w_c_done),
        .o_atan  (w_c_atan),
        .o_sin   (w_c_sin),
        .o_cos   (w_c_cos)
    );

    logic signed [15:0] r_polar, r_azim;
    logic [AW:0]        r_seg;
    logic [16:0]        r_frac;
    logic               r_first;
    logic [47:0]        r_pa;
    logic signed [33:0] r_d0, r_d1, r_d2;
    logic [15:0]        r_lr;
    logic signed [15:0] r_lt, r_lp;
    logic signed [35:0] r_sth, r_cth, r_sph, r_cph;
    logic signed [35:0] r_p1, r_p2;
    t_out_item          r_col;
    t_out_item          r_out;
    logic               r_out_valid;

    // segment arithmetic
    logic [4:0]  w_np;
    logic [4:0]  w_n;
    logic [21:0] w_tn;
    logic [5:0]  w_seg;
    assign w_np = (r_num_points < 5'd2) ? 5'd2 :
                  (32'(r_num_points) > MAX_POINTS) ? 5'(MAX_POINTS) : r_num_points;
    assign w_n   = w_np - 5'd1;
    assign w_tn  = 22'(r_item.position) * 22'(w_n);
    assign w_seg = 6'((w_tn + 22'd65535) >> 16);

    // position zero or above one: point 0 as is
    logic w_first;
    assign w_first = (r_item.position == 17'd0) || (r_item.position > 17'd65536);

    logic w_start_item;
    logic w_out_free;
    assign w_out_free   = !r_out_valid || !i_out_stall;
    assign w_start_item = (r_state == S_IDLE) && i_in_valid;
    assign o_in_stall   = (r_state != S_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:     if (w_start_item)
                            n_state = (i_in_data.func == FuncLoad) ? S_SQ_MUL : S_RD_A;
            S_SQ_MUL:   n_state = S_SQRT_RHO;
            S_SQRT_RHO: if (r_sq_i == 5'd17) n_state = S_SQRT_RAD;
            S_SQRT_RAD: if (r_sq_i == 5'd17) n_state = S_ATAN_POL;
            S_ATAN_POL: if (w_c_done || (r_item.point_z == 0)) n_state = S_ATAN_AZI;
            S_ATAN_AZI: if (w_c_done || (r_item.point_x == 0)) n_state = S_WRITE;
            S_WRITE:    n_state = S_IDLE;
            S_RD_A:     n_state = S_RD_B;
            S_RD_B:     n_state = S_LERP_MUL;
            S_LERP_MUL: n_state = S_LERP_ADD;
            S_LERP_ADD: n_state = S_SC_POL;
            S_SC_POL:   if (w_c_done) n_state = S_SC_AZI;
            S_SC_AZI:   if (w_c_done) n_state = S_MUL1;
            S_MUL1:     n_state = S_MUL2;
            S_MUL2:     n_state = S_MUL3;
            S_MUL3:     n_state = S_OUT;
            S_OUT:      if (w_out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // outputs to memory and CORDIC
    always_comb begin
        w_mem_we  = 1'b0;
        w_mem_re  = 1'b0;
        w_waddr   = AW'(r_item.point_index);
        w_raddr   = '0;
        w_wdata   = {r_radius[15:0], r_polar, r_azim};
        w_c_start = 1'b0;
        w_c_rot   = 1'b0;
        w_c_num   = '0;
        w_c_den   = '0;
        w_c_ang   = '0;
        case (r_state)
            S_WRITE: w_mem_we = (32'(r_item.point_index) < MAX_POINTS);
            S_RD_A: begin
                w_mem_re = 1'b1;
                w_raddr  = w_first ? '0 : AW'(w_seg - 6'd1);
            end
            S_RD_B: begin
                w_mem_re = 1'b1;
                w_raddr  = r_first ? '0 : AW'(r_seg);
            end
            S_ATAN_POL: begin
                w_c_start = !r_c_started && (r_item.point_z != 0);
                w_c_num   = 17'(signed'({1'b0, r_rho[15:0]}));
                w_c_den   = 17'(r_item.point_z);
            end
            S_ATAN_AZI: begin
                w_c_start = !r_c_started && (r_item.point_x != 0);
                w_c_num   = 17'(r_item.point_y);
                w_c_den   = 17'(r_item.point_x);
            end
            S_SC_POL: begin
                w_c_start = !r_c_started;
                w_c_rot   = 1'b1;
                w_c_ang   = r_lt;
            end
            S_SC_AZI: begin
                w_c_start = !r_c_started;
                w_c_rot   = 1'b1;
                w_c_ang   = r_lp;
            end
            default: ;
        endcase
    end

    logic signed [71:0] w_m1;
    logic signed [53:0] w_m2;
    assign w_m1 = r_sth * r_cph;
    assign w_m2 = $signed({1'b0, r_lr}) * r_p1;

    logic signed [33:0] w_l0, w_l1, w_l2;
    assign w_l0 = (r_d0 + 34'sd32768) >>> 16;
    assign w_l1 = (r_d1 + 34'sd32768) >>> 16;
    assign w_l2 = (r_d2 + 34'sd32768) >>> 16;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_num_points <= 5'd2;
            r_out_valid  <= 1'b0;
            r_c_started  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_num_points <= i_cfg_wdata;
            if (r_state == S_OUT && w_out_free) r_out_valid <= 1'b1;
            else if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            if (w_c_done || n_state != r_state) r_c_started <= 1'b0;
            else if (w_c_start) r_c_started <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: if (w_start_item) r_item <= i_in_data;
            S_SQ_MUL: begin
                r_sq_xy <= 34'(32'(r_item.point_x) * 32'(r_item.point_x))
                         + 34'(32'(r_item.point_y) * 32'(r_item.point_y));
                r_sq_zz <= 34'(32'(r_item.point_z) * 32'(r_item.point_z));
                r_sq_i  <= '0;
                r_sq_phase <= 1'b0;
            end
            S_SQRT_RHO, S_SQRT_RAD: begin
                if (r_sq_i == 5'd0 && !r_sq_phase) begin
                    r_rad <= (r_state == S_SQRT_RHO) ? r_sq_xy : r_sq_xy + r_sq_zz;
                    r_rem <= '0;
                    r_root <= '0;
                    r_sq_phase <= 1'b1;
                end else if (r_sq_i == 5'd17) begin
                    if (r_state == S_SQRT_RHO) r_rho <= r_root;
                    else r_radius <= r_root;
                    r_sq_i <= '0;
                    r_sq_phase <= 1'b0;
                end else begin
                    r_rad <= r_rad << 2;
                    if (w_rem_sh >= w_trial) begin
                        r_rem  <= w_rem_sh - w_trial;
                        r_root <= {r_root[15:0], 1'b1};
                    end else begin
                        r_rem  <= w_rem_sh;
                        r_root <= {r_root[15:0], 1'b0};
                    end
                    r_sq_i <= r_sq_i + 5'd1;
                end
            end
            S_ATAN_POL: begin
                if (r_item.point_z == 0) r_polar <= HalfPiQ13;
                else if (w_c_done) r_polar <= w_c_atan;
            end
            S_ATAN_AZI: begin
                if (r_item.point_x == 0) r_azim <= HalfPiQ13;
                else if (w_c_done) r_azim <= w_c_atan;
            end
            S_RD_A: begin
                r_first <= w_first;
                r_seg   <= (AW+1)'(w_seg);
                r_frac  <= 17'(w_tn - ({16'd0, w_seg} - 22'd1) * 22'd65536);
            end
            S_RD_B: r_pa <= r_rdata;
            S_LERP_MUL: begin
                r_d0 <= (34'(signed'({1'b0, r_rdata[47:32]})) -
                         34'(signed'({1'b0, r_pa[47:32]}))) * $signed({1'b0, r_frac});
                r_d1 <= (34'($signed(r_rdata[31:16])) - 34'($signed(r_pa[31:16])))
                        * $signed({1'b0, r_frac});
                r_d2 <= (34'($signed(r_rdata[15:0])) - 34'($signed(r_pa[15:0])))
                        * $signed({1'b0, r_frac});
            end
            S_LERP_ADD: begin
                if (r_first) begin
                    r_lr <= r_pa[47:32];
                    r_lt <= $signed(r_pa[31:16]);
                    r_lp <= $signed(r_pa[15:0]);
                end else begin
                    r_lr <= 16'(34'(r_pa[47:32]) + w_l0);
                    r_lt <= 16'(34'($signed(r_pa[31:16])) + w_l1);
                    r_lp <= 16'(34'($signed(r_pa[15:0])) + w_l2);
                end
            end
            S_SC_POL: if (w_c_done) begin
                r_sth <= w_c_sin;
                r_cth <= w_c_cos;
            end
            S_SC_AZI: if (w_c_done) begin
                r_sph <= w_c_sin;
                r_cph <= w_c_cos;
            end
            S_MUL1: begin
                r_p1 <= 36'((w_m1 + 72'sd536870912) >>> 30);
                r_p2 <= 36'((r_sth * r_sph + 72'sd536870912) >>> 30);
            end
            S_MUL2: begin
                r_col.color_x <= sat16(48'((w_m2 + 54'sd536870912) >>> 30));
                r_p1 <= r_p2;
            end
            S_MUL3: begin
                r_col.color_y <= sat16(48'((w_m2 + 54'sd536870912) >>> 30));
                r_col.color_z <= sat16(48'(($signed({1'b0, r_lr}) * r_cth
                                 + 54'sd536870912) >>> 30));
            end
            // hand over once the output register is free
            S_OUT: if (w_out_free) r_out <= r_col;
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_in_stall)
        else $error("input accepted while busy");
    a_out_from_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_OUT))
        else $error("result without evaluate");
    a_write_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |-> (r_item.func == FuncLoad))
        else $error("store written by evaluate");
`endif
endmodule

[verif/tb_spherical_color_gradient.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_spherical_color_gradient: self-checking bench for the gradient generator
// Loads control colors, evaluates positions under several point counts and
// checks every output color against an in-bench fixed-point palette model.
// ----------------------------------------------------------------------------
module tb_spherical_color_gradient;
    import scg_pkg::*;

    localparam int PTS = 16;
    localparam int CYCLE_LIMIT = 1000000;
    // a load gives no result to wait on; covers one in flight plus one offered
    localparam int SETTLE_CYCLES = 300;
    localparam int PHASE_ITEMS = 200;
    localparam longint HALF_PI = 12868;
    localparam longint GAIN_INV = 652032874;
    localparam longint ARC_TAB [17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                        256, 128, 64, 32, 16, 8, 4, 2, 1};

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [4:0] i_cfg_wdata = 5'd0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    t_in_item   i_in_data = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_item  o_out_data;

    spherical_color_gradient dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow of the block state: point count and the spherical point store.
    int        npoints_cfg = 2;
    longint    rad_mem [PTS];
    longint    pol_mem [PTS];
    longint    azi_mem [PTS];

    t_in_item  pending_q [$];     // transactions waiting to be offered
    t_out_item color_q [$];       // predicted colors, oldest first
    int        err_count = 0;
    int        accepted_cnt = 0;
    int        cycle_cnt = 0;
    bit        no_idle = 1'b0;    // phases with back-to-back traffic on both sides
    int        gap_left = 0;
    int        stall_left = 0;
    int        hold_left = 0;
    bit        hold_done = 1'b0;

    // ---------------- palette model ----------------

    function automatic longint isqrt64(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return longint'(res);
    endfunction

    // atan(num/den), den nonzero, result Q3.13
    function automatic longint arc_q13(longint num, longint den);
        longint x, y, acc, xs, ys;
        x = (den < 0 ? -den : den) * 65536;
        y = (den < 0 ? -num : num) * 65536;
        acc = 0;
        for (int i = 0; i < 17; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys; y = y - xs; acc += ARC_TAB[i];
            end else begin
                x = x - ys; y = y + xs; acc -= ARC_TAB[i];
            end
        end
        return (acc + 4) >>> 3;
    endfunction

    function automatic void rotate_q30(input longint ang, output longint s,
                                       output longint c);
        longint x, y, z, xs, ys;
        x = GAIN_INV;
        y = 0;
        z = ang * 8;
        for (int i = 0; i < 17; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys; y = y + xs; z -= ARC_TAB[i];
            end else begin
                x = x + ys; y = y - xs; z += ARC_TAB[i];
            end
        end
        s = y;
        c = x;
    endfunction

    function automatic longint round30(longint v);
        return (v + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic logic [15:0] clip16(longint v);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function automatic t_out_item sph_to_color(longint r, longint th, longint ph);
        t_out_item o;
        longint sth, cth, sph, cph;
        rotate_q30(th, sth, cth);
        rotate_q30(ph, sph, cph);
        o.color_x = clip16(round30(r * round30(sth * cph)));
        o.color_y = clip16(round30(r * round30(sth * sph)));
        o.color_z = clip16(round30(r * cth));
        return o;
    endfunction

    function automatic longint blend(longint a, longint b, longint frac);
        return a + (((b - a) * frac + 32768) >>> 16);
    endfunction

    // Applies one accepted transaction to the shadow state; evaluates queue a color.
    task automatic palette_apply(input t_in_item it);
        longint x, y, z, xy, rho, n, tn, seg, frac, pos;
        int np;
        if (it.func == FuncLoad) begin
            x = longint'($signed(it.point_x));
            y = longint'($signed(it.point_y));
            z = longint'($signed(it.point_z));
            xy = x * x + y * y;
            rho = isqrt64(xy);
            rad_mem[it.point_index] = isqrt64(xy + z * z);
            pol_mem[it.point_index] = (z == 0) ? HALF_PI : arc_q13(rho, z);
            azi_mem[it.point_index] = (x == 0) ? HALF_PI : arc_q13(y, x);
        end else begin
            np = npoints_cfg < 2 ? 2 : (npoints_cfg > PTS ? PTS : npoints_cfg);
            n = np - 1;
            pos = it.position;
            if (pos == 0 || pos > 65536) begin
                color_q.insert(color_q.size(),
                               sph_to_color(rad_mem[0], pol_mem[0], azi_mem[0]));
            end else begin
                tn = pos * n;
                seg = (tn + 65535) >>> 16;
                frac = tn - (seg - 1) * 65536;
                color_q.insert(color_q.size(), sph_to_color(
                    blend(rad_mem[seg-1], rad_mem[seg], frac),
                    blend(pol_mem[seg-1], pol_mem[seg], frac),
                    blend(azi_mem[seg-1], azi_mem[seg], frac)));
            end
        end
    endtask

    // ---------------- stimulus helpers ----------------

    task automatic queue_item(input t_in_item it);
        pending_q.insert(pending_q.size(), it);
    endtask

    function automatic logic [15:0] pick_comp();
        case ($urandom_range(0, 9))
            0: return 16'sd0;
            1: return 16'sd32767;
            2: return -16'sd32768;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_in_item load_item(int idx, logic [15:0] x, logic [15:0] y,
                                           logic [15:0] z);
        t_in_item it;
        it = '0;
        it.func = FuncLoad;
        it.point_index = idx[3:0];
        it.point_x = x;
        it.point_y = y;
        it.point_z = z;
        it.position = 17'($urandom);   // ignored by a load
        return it;
    endfunction

    function automatic t_in_item eval_item(int pos);
        t_in_item it;
        it = '0;
        it.func = FuncEval;
        it.point_index = 4'($urandom);
        it.point_x = 16'($urandom);
        it.point_y = 16'($urandom);
        it.point_z = 16'($urandom);
        it.position = pos[16:0];
        return it;
    endfunction

    // Positions weighted toward segment boundaries and the out-of-range cases.
    function automatic int pick_pos(int npts);
        int n, k, p;
        n = npts < 2 ? 1 : (npts > PTS ? PTS - 1 : npts - 1);
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 5))
                    0: p = 0;
                    1: p = 1;
                    2: p = 65535;
                    3: p = 65536;
                    4: p = 65537;
                    default: p = 131071;
                endcase
            end
            1, 2: begin
                k = $urandom_range(0, n);
                p = (k * 65536) / n + $urandom_range(0, 2) - 1;
                if (p < 0) p = 0;
            end
            3: p = $urandom_range(0, 131071);
            default: p = $urandom_range(1, 65536);
        endcase
        return p;
    endfunction

    task automatic wait_idle();
        while (pending_q.size() != 0 || i_in_valid || color_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_npoints(input int v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v[4:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        npoints_cfg = v;
    endtask

    // ---------------- driver ----------------
    // Acceptance is seen with pre-edge values; the next valid is decided once per edge.
    always @(posedge i_clk) begin
        logic     nxt_valid;
        t_in_item nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                palette_apply(i_in_data);
                accepted_cnt++;
            end
            if (i_in_valid && o_in_stall) begin
                nxt_valid = 1'b1;              // hold the stalled transaction
            end else if (gap_left > 0) begin
                gap_left--;
                nxt_valid = 1'b0;
            end else if (pending_q.size() != 0) begin
                nxt = pending_q.pop_front();
                i_in_data <= nxt;
                nxt_valid = 1'b1;
                gap_left = no_idle ? 0 : $urandom_range(0, 19);
            end else begin
                nxt_valid = 1'b0;
            end
            i_in_valid <= nxt_valid;
        end
    end

    // Long receiver hold-off once traffic is under way: fills the block so it
    // stalls its input while the driver keeps offering.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && accepted_cnt >= 300) begin
            hold_left <= 1500;
            hold_done <= 1'b1;
        end
    end

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (color_q.size() == 0) begin
                    $display("%0t: unexpected color transaction, actual %h", $time,
                             o_out_data);
                    err_count++;
                end else begin
                    want = color_q.pop_front();
                    if (o_out_data.color_x !== want.color_x) begin
                        $display("%0t: color_x expected %0d actual %0d", $time,
                                 $signed(want.color_x), $signed(o_out_data.color_x));
                        err_count++;
                    end
                    if (o_out_data.color_y !== want.color_y) begin
                        $display("%0t: color_y expected %0d actual %0d", $time,
                                 $signed(want.color_y), $signed(o_out_data.color_y));
                        err_count++;
                    end
                    if (o_out_data.color_z !== want.color_z) begin
                        $display("%0t: color_z expected %0d actual %0d", $time,
                                 $signed(want.color_z), $signed(o_out_data.color_z));
                        err_count++;
                    end
                end
                stall_left = no_idle ? 0 : $urandom_range(0, 19);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            i_out_stall <= (stall_left > 0) || (hold_left > 0);
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb_spherical_color_gradient: errors");
            $finish;
        end
    end

    // ---------------- test sequence ----------------
    initial begin
        int cfg_seq [8];
        int lo;
        cfg_seq = '{2, 0, 16, 1, 31, 17, 9, 5};
        cfg_seq[7] = $urandom_range(3, 15);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: corner colors (zero divisors, extremes, sign combinations) in
        // slots 0-7, random in 8-15, then position corners at the full point count.
        write_npoints(16);
        queue_item(load_item(0, 16'sd0, 16'sd0, 16'sd0));
        queue_item(load_item(1, 16'sd32767, 16'sd32767, 16'sd32767));
        queue_item(load_item(2, -16'sd32768, -16'sd32768, -16'sd32768));
        queue_item(load_item(3, 16'sd0, 16'sd16384, 16'sd8000));
        queue_item(load_item(4, 16'sd9000, -16'sd7000, 16'sd0));
        queue_item(load_item(5, -16'sd12000, 16'sd5000, -16'sd3000));
        queue_item(load_item(6, 16'sd0, 16'sd0, -16'sd32768));
        queue_item(load_item(7, 16'sd32767, -16'sd32768, 16'sd1));
        for (int i = 8; i < PTS; i++)
            queue_item(load_item(i, pick_comp(), pick_comp(), pick_comp()));
        queue_item(eval_item(0));
        queue_item(eval_item(1));
        queue_item(eval_item(4369));
        queue_item(eval_item(32768));
        queue_item(eval_item(65535));
        queue_item(eval_item(65536));
        queue_item(eval_item(65537));
        queue_item(eval_item(131071));
        wait_idle();

        // Random phases, each under its own point count, including the clamped ones.
        foreach (cfg_seq[p]) begin
            write_npoints(cfg_seq[p]);
            no_idle = (p % 3 == 2);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, 9) < 4) begin
                    lo = $urandom_range(0, PTS - 1);
                    queue_item(load_item(lo, pick_comp(), pick_comp(), pick_comp()));
                end else begin
                    queue_item(eval_item(pick_pos(cfg_seq[p])));
                end
            end
            wait_idle();
        end

        if (err_count == 0)
            $display("tb_spherical_color_gradient: clean");
        else
            $display("tb_spherical_color_gradient: errors");
        $finish;
    end

endmodule

[files.f]
sv/scg_pkg.sv
sv/scg_cordic.sv
sv/spherical_color_gradient.sv
verif/tb_spherical_color_gradient.sv
